// ===== rtl/acpd_pkg.sv =====
// Shared types and constants for the autocorrelation pitch detector.
// Depends on nothing; every other file of the block imports it.
package acpd_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SUM_W       = ADDR_W + 9;
    localparam int FS_W        = 18;
    localparam int TF_W        = 16;
    localparam int THR_W       = SUM_W + TF_W + 1;
    localparam int DEN_W       = CNT_W + SUM_W + 1;
    localparam int NUM_W       = FS_W + SUM_W - 1 + 8;
    localparam int FREQ_W      = 26;
    localparam int PMS_W       = 18;

    localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_SAMPLES);
    localparam logic [FREQ_W-1:0] FREQ_MAX  = '1;
    localparam logic [PMS_W-1:0]  PMS_MAX   = '1;
    localparam logic [FS_W-1:0]   MS_SCALE  = FS_W'(256000);
    localparam logic [FS_W-1:0]   FS_RESET  = FS_W'(48000);
    localparam logic [TF_W-1:0]   TF_RESET  = TF_W'(32768);

    localparam logic REG_FS = 1'b0;
    localparam logic REG_TF = 1'b1;

    typedef struct packed {
        logic [7:0] sample;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency_q8;
        logic [PMS_W-1:0]  period_ms_q8;
        logic [9:0]        period_lag;
        logic              found;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } ram_wr_t;

    typedef struct packed {
        logic             push;
        logic [CNT_W-1:0] len;
    } job_t;

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_ARMED, PH_FOUND} phase_t;

    typedef enum logic [3:0] {
        B_IDLE, B_LAG, B_RUN, B_DRAIN, B_EVAL, B_DEN,
        B_FSTART, B_FWAIT, B_PSTART, B_PWAIT, B_DONE
    } back_state_t;

    // Product of two centred samples divided by 256, truncated toward zero.
    function automatic logic signed [SUM_W-1:0] lag_term(input logic [7:0] a,
                                                         input logic [7:0] b);
        logic signed [7:0]  ca;
        logic signed [7:0]  cb;
        logic signed [16:0] p;
        logic signed [16:0] q;
        ca = signed'(a ^ 8'h80);
        cb = signed'(b ^ 8'h80);
        p  = 17'(ca * cb);
        q  = (p + (p[16] ? 17'sd255 : 17'sd0)) >>> 8;
        return SUM_W'(q);
    endfunction

endpackage

// ===== rtl/acpd_frame_ram.sv =====
// Frame sample memory: one write port and two registered read ports.
// Depends on acpd_pkg.
module acpd_frame_ram (
    input  logic                          clk,
    input  acpd_pkg::ram_wr_t             wr,
    input  logic [acpd_pkg::ADDR_W-1:0]   rd_addr_a,
    input  logic [acpd_pkg::ADDR_W-1:0]   rd_addr_b,
    output logic [7:0]                    rd_data_a,
    output logic [7:0]                    rd_data_b
);
    import acpd_pkg::*;

    logic [7:0] mem [MAX_SAMPLES];

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr.wr_addr] <= wr.wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/acpd_front.sv =====
// Front end: takes sample transactions, fills the frame memory and hands
// finished frames to the job queue. Depends on acpd_pkg.
module acpd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  acpd_pkg::item_t   item,
    input  logic              job_full,
    input  logic              mem_busy,
    output acpd_pkg::ram_wr_t wr,
    output acpd_pkg::job_t    job
);
    import acpd_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic             room;

    assign full   = job_full | mem_busy;
    assign accept = push & ~full;
    assign room   = count_reg < MAX_COUNT;

    assign wr.wr_en   = accept & room;
    assign wr.wr_addr = count_reg[ADDR_W-1:0];
    assign wr.wr_data = item.sample;

    // Samples beyond the frame limit are dropped, but a last mark still counts.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (item.last)
            begin
                count_next = '0;
            end
            else if (room)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    assign job.push = accept & item.last;
    assign job.len  = room ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/acpd_job_queue.sv =====
// Single-entry queue of frame lengths between the front and back ends.
// Depends on acpd_pkg.
module acpd_job_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  acpd_pkg::job_t               job,
    input  logic                         pop,
    output logic                         valid,
    output logic [acpd_pkg::CNT_W-1:0]   len
);
    import acpd_pkg::*;

    logic             valid_reg;
    logic [CNT_W-1:0] len_reg;

    assign valid = valid_reg;
    assign len   = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (job.push)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.push)
        begin
            len_reg <= job.len;
        end
    end

endmodule

// ===== rtl/acpd_div.sv =====
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// Depends on acpd_pkg.
module acpd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [acpd_pkg::NUM_W-1:0]   dividend,
    input  logic [acpd_pkg::DEN_W-1:0]   divisor,
    output logic                         done,
    output logic [acpd_pkg::NUM_W-1:0]   quotient
);
    import acpd_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  dvs_reg;
    logic [DEN_W:0]    shifted;
    logic              ge;

    assign shifted  = {rem_reg, quo_reg[NUM_W-1]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == STEP_W'(1));
            if (start)
            begin
                step_reg <= STEP_W'(NUM_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            rem_reg <= ge ? DEN_W'(shifted - {1'b0, dvs_reg}) : DEN_W'(shifted);
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

endmodule

// ===== rtl/acpd_back.sv =====
// Back end: lag-by-lag correlation sequencer, period detection, frequency and
// period conversion, and the result register. Depends on acpd_pkg, acpd_div.
module acpd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    input  logic [acpd_pkg::CNT_W-1:0]   job_len,
    output logic                         job_pop,
    output logic                         mem_busy,
    output logic [acpd_pkg::ADDR_W-1:0]  rd_addr_a,
    output logic [acpd_pkg::ADDR_W-1:0]  rd_addr_b,
    input  logic [7:0]                   rd_data_a,
    input  logic [7:0]                   rd_data_b,
    input  logic [acpd_pkg::FS_W-1:0]    fs,
    input  logic [acpd_pkg::TF_W-1:0]    tf,
    output logic                         empty,
    input  logic                         pop,
    output acpd_pkg::result_t            result
);
    import acpd_pkg::*;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [CNT_W-1:0]         n_reg;
    logic [ADDR_W-1:0]        lag_reg;
    logic [ADDR_W-1:0]        j_reg;
    logic                     iss_reg;
    logic signed [SUM_W-1:0]  cur_reg;
    logic signed [SUM_W-1:0]  prev_reg;
    logic signed [SUM_W-1:0]  energy_reg;
    logic signed [SUM_W-1:0]  psum_reg;
    logic signed [THR_W-1:0]  thr_reg;
    phase_t                   phase_reg;
    phase_t                   phase_new;
    logic [ADDR_W-1:0]        period_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [FREQ_W-1:0]        freq_reg;
    logic [PMS_W-1:0]         pms_reg;
    result_t                  res_reg;
    logic                     res_valid_reg;

    logic                     last_issue;
    logic                     last_lag;
    logic signed [THR_W-1:0]  cur_scaled;
    logic                     div_start;
    logic [NUM_W-1:0]         div_dividend;
    logic [DEN_W-1:0]         div_divisor;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quo;
    logic                     load_res;

    assign last_issue = (CNT_W'(j_reg) + CNT_W'(lag_reg)) == (n_reg - 1'b1);
    assign last_lag   = CNT_W'(lag_reg) == (n_reg - 1'b1);
    assign cur_scaled = {cur_reg[SUM_W-1], cur_reg, 16'b0};
    assign rd_addr_a  = j_reg;
    assign rd_addr_b  = j_reg + lag_reg;
    assign empty      = ~res_valid_reg;
    assign result     = res_reg;

    // Detection step for the lag just summed.
    always_comb
    begin
        phase_new = phase_reg;
        if (phase_new == PH_ARMED && cur_reg <= prev_reg)
        begin
            phase_new = PH_FOUND;
        end
        if (phase_new == PH_WAIT && cur_scaled > thr_reg && cur_reg > prev_reg)
        begin
            phase_new = PH_ARMED;
        end
        if (lag_reg == '0)
        begin
            phase_new = PH_WAIT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (job_valid) state_next = B_LAG;
            B_LAG:    state_next = B_RUN;
            B_RUN:    if (last_issue) state_next = B_DRAIN;
            B_DRAIN:  state_next = B_EVAL;
            B_EVAL:
            begin
                if (phase_new == PH_FOUND)
                begin
                    state_next = B_DEN;
                end
                else if (last_lag)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_LAG;
                end
            end
            B_DEN:    state_next = B_FSTART;
            B_FSTART:
            begin
                if (fs == '0)
                begin
                    state_next = B_DONE;
                end
                else if (den_reg <= 0)
                begin
                    state_next = B_PSTART;
                end
                else
                begin
                    state_next = B_FWAIT;
                end
            end
            B_FWAIT:  if (div_done) state_next = B_PSTART;
            B_PSTART: state_next = B_PWAIT;
            B_PWAIT:  if (div_done) state_next = B_DONE;
            B_DONE:   if (!res_valid_reg) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop      = 1'b0;
        mem_busy     = 1'b0;
        div_start    = 1'b0;
        div_dividend = num_reg;
        div_divisor  = den_reg;
        load_res     = 1'b0;
        case (state_reg)
            B_IDLE:   job_pop = job_valid;
            B_LAG,
            B_RUN,
            B_DRAIN,
            B_EVAL:   mem_busy = 1'b1;
            B_FSTART: div_start = (fs != '0) && (den_reg > 0);
            B_PSTART:
            begin
                div_start    = 1'b1;
                div_dividend = NUM_W'(period_reg * MS_SCALE);
                div_divisor  = DEN_W'(fs);
            end
            B_DONE:   load_res = ~res_valid_reg;
            default:  job_pop = 1'b0;
        endcase
    end

    acpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            iss_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
            iss_reg <= (state_reg == B_RUN);
            if (state_reg == B_IDLE && job_valid)
            begin
                phase_reg <= PH_IDLE;
            end
            else if (state_reg == B_EVAL)
            begin
                phase_reg <= phase_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_reg)
        begin
            cur_reg <= cur_reg + lag_term(rd_data_a, rd_data_b);
        end
        case (state_reg)
            B_IDLE:
            begin
                n_reg    <= job_len;
                lag_reg  <= '0;
                prev_reg <= '0;
            end
            B_LAG:
            begin
                cur_reg <= '0;
                j_reg   <= '0;
            end
            B_RUN:    j_reg <= j_reg + 1'b1;
            B_EVAL:
            begin
                prev_reg <= cur_reg;
                lag_reg  <= lag_reg + 1'b1;
                if (phase_reg == PH_ARMED && phase_new == PH_FOUND)
                begin
                    period_reg <= lag_reg;
                    psum_reg   <= cur_reg;
                end
                if (lag_reg == '0)
                begin
                    energy_reg <= cur_reg;
                    thr_reg    <= THR_W'(cur_reg * $signed({1'b0, tf}));
                end
            end
            B_DEN:
            begin
                den_reg <= DEN_W'($signed({1'b0, period_reg - 1'b1}) * energy_reg)
                           + DEN_W'(psum_reg);
                num_reg <= {(NUM_W-8)'(fs * energy_reg[SUM_W-2:0]), 8'b0};
            end
            B_FSTART:
            begin
                if (fs == '0)
                begin
                    freq_reg <= '0;
                    pms_reg  <= PMS_MAX;
                end
                else if (den_reg <= 0)
                begin
                    freq_reg <= FREQ_MAX;
                end
            end
            B_FWAIT:
            begin
                if (div_done)
                begin
                    freq_reg <= (div_quo > NUM_W'(FREQ_MAX)) ? FREQ_MAX
                                                            : div_quo[FREQ_W-1:0];
                end
            end
            B_PWAIT:
            begin
                if (div_done)
                begin
                    pms_reg <= (div_quo > NUM_W'(PMS_MAX)) ? PMS_MAX
                                                          : div_quo[PMS_W-1:0];
                end
            end
            B_DONE:
            begin
                if (load_res)
                begin
                    if (phase_reg == PH_FOUND)
                    begin
                        res_reg.frequency_q8 <= freq_reg;
                        res_reg.period_ms_q8 <= pms_reg;
                        res_reg.period_lag   <= period_reg;
                        res_reg.found        <= 1'b1;
                    end
                    else
                    begin
                        res_reg <= '0;
                    end
                end
            end
            default:
            begin
                j_reg <= j_reg;
            end
        endcase
    end

endmodule

// ===== rtl/autocorrelation_pitch_detector.sv =====
// Top level of the autocorrelation pitch detector: configuration registers
// and the wiring of front end, job queue, frame memory and back end.
// Depends on acpd_pkg and all acpd_* modules.
//
//   Channel     Handshake                       Moves
//   ---------   -----------------------------   ---------------------------------
//   item        push / full                     one sample transaction
//   result      pop / empty                     one analysis result per frame
//   config      psel, penable, pwrite, pready   sampling_rate (0), threshold (4)
//
// A frame of n samples keeps the frame memory busy while its lags are correlated
// (one multiply-accumulate per cycle through the dual-read memory), after which
// the conversion runs on the shared bit-serial divider before the result appears.
// Reset is asynchronous and active low; it empties the frame and the queues
// but leaves the memory contents, which are only read after being written.
// While a frame waits in the job queue or is being correlated, full is high;
// samples of the next frame are taken during conversion and while a result
// waits to be popped.
module autocorrelation_pitch_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  acpd_pkg::item_t             item,
    output logic                        empty,
    input  logic                        pop,
    output acpd_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import acpd_pkg::*;

    logic [FS_W-1:0]   fs_reg;
    logic [TF_W-1:0]   tf_reg;
    logic              cfg_write;
    ram_wr_t           ram_wr;
    job_t              job;
    logic              job_valid;
    logic [CNT_W-1:0]  job_len;
    logic              job_pop;
    logic              mem_busy;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [7:0]        rd_data_a;
    logic [7:0]        rd_data_b;

    // The port never inserts wait states; register index is paddr bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        case (paddr[2])
            REG_FS:  prdata = 32'(fs_reg);
            REG_TF:  prdata = 32'(tf_reg);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= FS_RESET;
            tf_reg <= TF_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_FS:  fs_reg <= pwdata[FS_W-1:0];
                REG_TF:  tf_reg <= pwdata[TF_W-1:0];
                default: fs_reg <= fs_reg;
            endcase
        end
    end

    acpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_full (job_valid),
        .mem_busy (mem_busy),
        .wr       (ram_wr),
        .job      (job)
    );

    acpd_job_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job),
        .pop   (job_pop),
        .valid (job_valid),
        .len   (job_len)
    );

    acpd_frame_ram u_ram (
        .clk       (clk),
        .wr        (ram_wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    acpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_len   (job_len),
        .job_pop   (job_pop),
        .mem_busy  (mem_busy),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .fs        (fs_reg),
        .tf        (tf_reg),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== rtl/acpd_checker.sv =====
// Port-level checks for the autocorrelation pitch detector, bound to the top.
// Depends on acpd_pkg.
module acpd_port_checks (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  logic              pop,
    input  logic              pready,
    input  acpd_pkg::result_t result
);
    import acpd_pkg::*;

    // A result without a period carries all-zero fields.
    a_zero_when_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.found) |->
        (result.frequency_q8 == '0 && result.period_ms_q8 == '0 && result.period_lag == '0))
        else $error("result without period has nonzero fields");

    // A period is at least two lags, since arming needs one rising lag first.
    a_period_min: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.found) |-> (result.period_lag > 10'd1))
        else $error("found period shorter than two lags");

    // A waiting result that is not taken holds still.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port inserted a wait state");

endmodule

bind autocorrelation_pitch_detector acpd_port_checks u_acpd_port_checks (.*);
